FILE: src/conveyor_shift_buffer_unit_macros.svh
// Assertion macros for the conveyor shift buffer checker.
// No dependencies; included by the checker file.
`ifndef CONVEYOR_SHIFT_BUFFER_UNIT_MACROS_SVH
`define CONVEYOR_SHIFT_BUFFER_UNIT_MACROS_SVH

// clocked assertion, masked during reset
`define CSB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion that also holds in reset
`define CSB_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/csb_pkg.sv
// Shared types, constants and helpers for the conveyor shift buffer.
// No dependencies.
package csb_pkg;

	localparam int MAX_SLOTS    = 16;
	localparam int PAYLOAD_BITS = 16;
	localparam int IDX_W        = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W        = $clog2(MAX_SLOTS + 1);
	localparam int LEN_W        = 5;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_TICK   = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);

	typedef logic [PAYLOAD_BITS-1:0] slot_data_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] payload_in;
	} in_word_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] payload_out;
		logic [4:0]  occupancy;
	} out_word_t;

	typedef struct packed {
		logic tick;
		logic insert;
		logic remove;
		logic in_range;
	} cell_ctrl_t;

	function automatic slot_data_t to_slot(input logic [15:0] p);
		logic [79:0] w;
		w = 80'(p);
		return w[PAYLOAD_BITS-1:0];
	endfunction

	function automatic logic [15:0] from_slot(input slot_data_t s);
		logic [79:0] w;
		w = 80'(s);
		return w[15:0];
	endfunction

endpackage

FILE: src/csb_cell.sv
// One conveyor slot: valid bit and payload, moves toward the exit on a tick.
// Depends on csb_pkg.
module csb_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  csb_pkg::cell_ctrl_t ctrl,
	input  logic                prev_full,
	input  csb_pkg::slot_data_t prev_payload,
	input  logic                hole_in,
	input  csb_pkg::slot_data_t payload_in,
	output logic                full,
	output csb_pkg::slot_data_t payload,
	output logic                hole_out
);
	import csb_pkg::*;

	logic       full_q;
	slot_data_t payload_q;
	logic       recv;
	logic       vacate;
	logic       insert_ok;

	// hole at this slot or somewhere ahead, reachable through a packed run
	assign hole_out  = ctrl.in_range & (~full_q | hole_in);
	assign recv      = ctrl.tick & prev_full & hole_out;
	assign vacate    = ctrl.tick & ctrl.in_range & full_q & hole_in;
	assign insert_ok = ctrl.insert & ~full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (insert_ok || recv) begin
			full_q <= 1'b1;
		end else if (vacate || (ctrl.remove && full_q)) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (insert_ok) begin
			payload_q <= payload_in;
		end else if (recv) begin
			payload_q <= prev_payload;
		end
	end

	assign full    = full_q;
	assign payload = payload_q;

endmodule

FILE: src/csb_out_skid.sv
// Result output register with one skid entry.
// Depends on csb_pkg.
module csb_out_skid (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  csb_pkg::out_word_t push_word,
	output logic               busy,
	output logic               valid,
	input  logic               stall,
	output csb_pkg::out_word_t word
);
	import csb_pkg::*;

	logic      valid_q;
	logic      skid_valid_q;
	out_word_t word_q;
	out_word_t skid_q;
	logic      take;

	assign take = valid_q & ~stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				valid_q <= 1'b1;
			end
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				word_q <= skid_q;
			end
		end else if (push) begin
			if (valid_q && !take) begin
				skid_q <= push_word;
			end else begin
				word_q <= push_word;
			end
		end
	end

	assign busy  = skid_valid_q;
	assign valid = valid_q;
	assign word  = word_q;

endmodule

FILE: src/conveyor_shift_buffer_unit.sv
// Conveyor shift buffer top level: row of slot cells, occupancy count, output skid.
// Depends on csb_pkg, csb_cell, csb_out_skid.
//
// Usage:
//   in channel  (in_valid / in_stall / in_word): one op per word, insert at the
//     entry slot, tick the conveyor one step, or remove from the exit slot.
//   out channel (out_valid / out_stall / out_word): one result word per op with
//     ok, removed payload and occupancy after the op.
//   cfg_we / cfg_wdata: writes length_in_use; write only while idle.
// Result: registered into the output register, or into the skid entry while the output is stalled.
// Throughput: one op per cycle while in_stall is low; every slot cell updates in the same cycle,
//   the tick move resolves through a hole-ahead chain running from exit to entry.
// Stall: the output register plus one skid entry hold results; in_stall rises
//   once both are full and drops as soon as the receiver takes a word.
// Reset: all slots empty, occupancy zero, length 16, no result pending.
module conveyor_shift_buffer_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  csb_pkg::in_word_t        in_word,
	output logic                     out_valid,
	input  logic                     out_stall,
	output csb_pkg::out_word_t       out_word,
	input  logic                     cfg_we,
	input  logic [csb_pkg::LEN_W-1:0] cfg_wdata
);
	import csb_pkg::*;

	logic [LEN_W-1:0] len_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic [CNT_W-1:0] len_eff;
	logic [IDX_W-1:0] last_idx;
	logic             acc;
	logic             do_insert;
	logic             do_tick;
	logic             do_remove;
	logic             insert_ok;
	logic             remove_ok;
	logic             busy;
	out_word_t        res;

	logic       full_v [MAX_SLOTS];
	slot_data_t pay_v  [MAX_SLOTS];
	logic       hole_v [MAX_SLOTS];
	cell_ctrl_t ctrl_v [MAX_SLOTS];
	slot_data_t pin;

	assign acc       = in_valid & ~in_stall;
	assign do_insert = acc & (in_word.op == OP_INSERT);
	assign do_tick   = acc & (in_word.op == OP_TICK);
	assign do_remove = acc & (in_word.op == OP_REMOVE);
	assign pin       = to_slot(in_word.payload_in);

	always_comb begin
		if (len_q == '0) begin
			len_eff = CNT_W'(1);
		end else if (32'(len_q) > MAX_SLOTS) begin
			len_eff = CNT_W'(MAX_SLOTS);
		end else begin
			len_eff = CNT_W'(len_q);
		end
	end
	assign last_idx = IDX_W'(len_eff - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
		end else if (cfg_we) begin
			len_q <= cfg_wdata;
		end
	end

	for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
		logic prev_full;
		slot_data_t prev_pay;
		logic hole_in;
		if (i == 0) begin : g_entry
			assign prev_full = 1'b0;
			assign prev_pay  = '0;
		end else begin : g_mid
			assign prev_full = full_v[i-1];
			assign prev_pay  = pay_v[i-1];
		end
		if (i == MAX_SLOTS - 1) begin : g_end
			assign hole_in = 1'b0;
		end else begin : g_link
			assign hole_in = hole_v[i+1];
		end

		assign ctrl_v[i].tick     = do_tick;
		assign ctrl_v[i].insert   = do_insert & (i == 0);
		assign ctrl_v[i].remove   = do_remove & (IDX_W'(i) == last_idx);
		assign ctrl_v[i].in_range = CNT_W'(i) < len_eff;

		csb_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl_v[i]),
			.prev_full   (prev_full),
			.prev_payload(prev_pay),
			.hole_in     (hole_in),
			.payload_in  (pin),
			.full        (full_v[i]),
			.payload     (pay_v[i]),
			.hole_out    (hole_v[i])
		);
	end

	assign insert_ok = do_insert & ~full_v[0];
	assign remove_ok = do_remove & full_v[last_idx];

	always_comb begin
		count_d = count_q;
		if (insert_ok) begin
			count_d = count_q + CNT_W'(1);
		end else if (remove_ok && count_q != '0) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_comb begin
		res.ok          = insert_ok | remove_ok;
		res.payload_out = remove_ok ? from_slot(pay_v[last_idx]) : 16'd0;
		res.occupancy   = 5'(count_d);
	end

	csb_out_skid u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (acc),
		.push_word(res),
		.busy     (busy),
		.valid    (out_valid),
		.stall    (out_stall),
		.word     (out_word)
	);

	assign in_stall = busy;

endmodule

FILE: src/csb_checker.sv
// Port-level checks for the conveyor shift buffer, bound to the top level.
// Depends on csb_pkg and conveyor_shift_buffer_unit_macros.svh.
`include "conveyor_shift_buffer_unit_macros.svh"

module csb_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input csb_pkg::out_word_t        out_word
);
	import csb_pkg::*;

	`CSB_ASSERT(a_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_word)), "result word changed while stalled")
	`CSB_ASSERT(a_accept_out, (in_valid && !in_stall) |=> out_valid, "accepted op left no result")
	`CSB_ASSERT_ALWAYS(a_stall_full, in_stall |-> out_valid, "input stalled with empty output")
	`CSB_ASSERT(a_payload_ok, (out_valid && out_word.payload_out != 16'd0) |-> out_word.ok, "payload returned without ok")
	`CSB_ASSERT(a_occ_max, out_valid |-> (32'(out_word.occupancy) <= MAX_SLOTS), "occupancy above slot count")

endmodule

bind conveyor_shift_buffer_unit csb_checker u_csb_checker (.*);

FILE: dv/testbench.sv
// Testbench for conveyor_shift_buffer_unit: directed and random insert, tick and remove
// words checked against a cycle-free mirror of the slot row, across several lengths.
// Depends on csb_pkg and the conveyor_shift_buffer_unit RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import csb_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 3000;
	localparam int RANDOM_OPS = 500;
	localparam int HOLD_CYCLES = 120;

	// mirror of the slot row; predicts the result word of every accepted op
	class conveyor_mirror;
		bit filled [MAX_SLOTS];
		slot_data_t held [MAX_SLOTS];
		logic [4:0] occupied;
		logic [LEN_W-1:0] length_reg;
		out_word_t pending_results[$];
		int unsigned errors, ops, taken, refused, removed, ticks;

		function new();
			foreach (filled[i]) filled[i] = 1'b0;
			occupied = '0;
			length_reg = LEN_RESET;
			errors = 0; ops = 0; taken = 0; refused = 0; removed = 0; ticks = 0;
		endfunction

		function void set_length(logic [LEN_W-1:0] v);
			length_reg = v;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void apply_op(in_word_t w);
			int last;
			out_word_t r;
			if (length_reg == 0)
				last = 0;
			else if (length_reg > MAX_SLOTS)
				last = MAX_SLOTS - 1;
			else
				last = int'(length_reg) - 1;
			r = '0;
			case (w.op)
				OP_INSERT: begin
					if (!filled[0]) begin
						filled[0] = 1'b1;
						held[0] = slot_data_t'(w.payload_in);
						occupied++;
						r.ok = 1'b1;
						taken++;
					end else begin
						refused++;
					end
				end
				OP_TICK: begin
					// exit to entry, so a packed run moves as one
					for (int i = last; i > 0; i--) begin
						if (!filled[i] && filled[i-1]) begin
							filled[i] = 1'b1;
							held[i] = held[i-1];
							filled[i-1] = 1'b0;
						end
					end
					ticks++;
				end
				OP_REMOVE: begin
					if (filled[last]) begin
						r.payload_out = 16'(held[last]);
						filled[last] = 1'b0;
						if (occupied != 0)
							occupied--;
						r.ok = 1'b1;
						removed++;
					end
				end
				default: ;
			endcase
			if (w.op != OP_UNUSED)
				ops++;
			r.occupancy = occupied;
			pending_results.push_back(r);
		endfunction

		function void check_result(out_word_t got);
			out_word_t want;
			if (pending_results.size() == 0) begin
				$error("unexpected result word %h", got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.ok !== want.ok) begin
				$error("ok: expected %0d, got %0d", want.ok, got.ok);
				errors++;
			end
			if (got.payload_out !== want.payload_out) begin
				$error("payload_out: expected %h, got %h", want.payload_out, got.payload_out);
				errors++;
			end
			if (got.occupancy !== want.occupancy) begin
				$error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_word_t in_word;
	logic out_valid;
	logic out_stall;
	out_word_t out_word;
	logic cfg_we;
	logic [LEN_W-1:0] cfg_wdata;

	conveyor_mirror mirror;
	int burst_left;
	bit no_gaps;
	bit hold_request;
	int idle_cycles;
	int stall_cycles;
	int lengths_used;

	conveyor_shift_buffer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic in_word_t mk(logic [1:0] op, logic [15:0] payload);
		in_word_t w;
		w.op = op;
		w.payload_in = payload;
		return w;
	endfunction

	function automatic in_word_t random_op();
		int r;
		r = $urandom_range(99, 0);
		if (r < 32)
			return mk(OP_INSERT, 16'($urandom()));
		else if (r < 74)
			return mk(OP_TICK, 16'($urandom()));
		else if (r < 95)
			return mk(OP_REMOVE, 16'($urandom()));
		return mk(OP_UNUSED, 16'($urandom()));
	endfunction

	function automatic logic [LEN_W-1:0] pick_length();
		int r;
		r = $urandom_range(99, 0);
		if (r < 40)
			return LEN_W'($urandom_range(4, 1));
		else if (r < 70)
			return LEN_W'($urandom_range(10, 5));
		else if (r < 85)
			return LEN_W'(MAX_SLOTS);
		return LEN_W'($urandom_range(31, 0));
	endfunction

	task automatic send_op(input in_word_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(24, 1);
			gap = ($urandom_range(9, 0) < 3 || no_gaps) ? 0 : $urandom_range(7, 1);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
		mirror.apply_op(w);
	endtask

	// only while idle: every expected word has come back
	task automatic write_length(input logic [LEN_W-1:0] v);
		in_valid <= 1'b0;
		do @(posedge clk); while (mirror.pending() != 0);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		mirror.set_length(v);
		cfg_we <= 1'b0;
		lengths_used++;
	endtask

	// receiver: stall pattern in segments, plus a long hold on request
	initial begin
		int seg_left, mode, hold_left;
		seg_left = 0;
		mode = 0;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				mirror.check_result(out_word);
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (seg_left == 0) begin
				seg_left = $urandom_range(60, 10);
				mode = $urandom_range(2, 0);
			end
			seg_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(3, 0) == 0);
					default: out_stall <= ($urandom_range(9, 0) < 7);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (in_valid && in_stall)
			stall_cycles++;
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int n, phase, random_ops;
		mirror = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		burst_left = 0;
		no_gaps = 1'b0;
		hold_request = 1'b0;
		idle_cycles = 0;
		stall_cycles = 0;
		lengths_used = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty row, refusal, unused code, full-width payloads
		send_op(mk(OP_REMOVE, 16'h0000));
		send_op(mk(OP_TICK, 16'hFFFF));
		send_op(mk(OP_UNUSED, 16'hFFFF));
		send_op(mk(OP_INSERT, 16'hFFFF));
		send_op(mk(OP_INSERT, 16'h0000));
		send_op(mk(OP_TICK, 16'h0000));
		send_op(mk(OP_INSERT, 16'h0000));
		send_op(mk(OP_TICK, 16'h0000));
		send_op(mk(OP_REMOVE, 16'h0000));
		// shrink while loaded: frozen slots still counted; entry is exit
		write_length(LEN_W'(1));
		send_op(mk(OP_INSERT, 16'h5A5A));
		send_op(mk(OP_INSERT, 16'h1234));
		send_op(mk(OP_TICK, 16'h0000));
		send_op(mk(OP_REMOVE, 16'h0000));
		send_op(mk(OP_REMOVE, 16'h0000));
		write_length(LEN_W'(0));
		send_op(mk(OP_INSERT, 16'h8001));
		send_op(mk(OP_UNUSED, 16'h0000));
		send_op(mk(OP_REMOVE, 16'h0000));
		write_length(LEN_W'(31));
		send_op(mk(OP_TICK, 16'h0000));
		send_op(mk(OP_TICK, 16'h0000));
		send_op(mk(OP_TICK, 16'h0000));
		write_length(LEN_W'(2));
		send_op(mk(OP_INSERT, 16'h7FFE));
		send_op(mk(OP_TICK, 16'h0000));
		send_op(mk(OP_INSERT, 16'h0001));
		send_op(mk(OP_REMOVE, 16'h0000));
		send_op(mk(OP_TICK, 16'h0000));
		send_op(mk(OP_REMOVE, 16'h0000));

		random_ops = 0;
		for (phase = 0; random_ops < RANDOM_OPS; phase++) begin
			write_length(pick_length());
			if (phase == 3 || phase == 9) begin
				no_gaps = 1'b1;
				hold_request = 1'b1;
			end
			n = 0;
			while (n < 40 && random_ops < RANDOM_OPS) begin
				in_word_t w;
				w = random_op();
				send_op(w);
				if (w.op != OP_UNUSED) begin
					n++;
					random_ops++;
				end
			end
			no_gaps = 1'b0;
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (mirror.pending() != 0);
		repeat (4) @(posedge clk);

		$display("ran %0d ops over %0d length settings: %0d inserts taken, %0d refused,",
			mirror.ops, lengths_used, mirror.taken, mirror.refused);
		$display("%0d words removed, %0d ticks, input held off for %0d cycles",
			mirror.removed, mirror.ticks, stall_cycles);
		if (mirror.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
